// File: src/sis_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sis_pkg
// Shared types and constants for the signed 64-bit set sorter.
// ---------------------------------------------------------------------------
package sis_pkg;

    localparam int VALUE_W              = 64;
    localparam int MAX_ELEMENTS_DEFAULT = 64;

    typedef logic signed [VALUE_W-1:0] sis_value_t;

    // Broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic       insert;     // place new_value into the sorted chain
        logic       shift;      // move every entry one cell toward the head
        sis_value_t new_value;
    } sis_ctrl_t;

endpackage

// File: src/sis_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sis_in_if / sis_out_if
// Valid/ready channels for input elements and sorted results.
// ---------------------------------------------------------------------------
interface sis_in_if;
    logic                valid;
    logic                ready;
    sis_pkg::sis_value_t value;
    logic                last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface sis_out_if;
    logic                valid;
    logic                ready;
    sis_pkg::sis_value_t sorted_value;
    logic                last_out;
    logic                overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflow, output ready);
endinterface

// File: src/sis_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sis_cell
// One slot of the insertion chain: holds one element and its valid bit.
// ---------------------------------------------------------------------------
module sis_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sis_pkg::sis_ctrl_t  ctrl,
    input  logic                prev_take,
    input  logic                prev_valid,
    input  sis_pkg::sis_value_t prev_value,
    input  logic                next_valid,
    input  sis_pkg::sis_value_t next_value,
    output logic                take,
    output logic                valid,
    output sis_pkg::sis_value_t value
);
    import sis_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    sis_value_t value_reg;
    sis_value_t value_next;

    // Empty slots act as +infinity, so the chain stays sorted with holes at the tail
    assign take = !valid_reg || (ctrl.new_value < value_reg);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
        else if (ctrl.insert && take)
        begin
            // Push the displaced neighbor down, or take the new element here
            if (prev_take)
            begin
                valid_next = prev_valid;
                value_next = prev_value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = ctrl.new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

// File: src/signed_int64_set_sorter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int64_set_sorter_core
// Systolic insertion sorter for sets of signed 64-bit integers.
// ---------------------------------------------------------------------------
// Elements enter one per cycle outside the drain and are placed in sorted
// position in a chain of MAX_ELEMENTS cells, each comparing the incoming
// element with its own entry. Elements beyond MAX_ELEMENTS are dropped and
// flag every result of the set. The transfer that carries last_in starts the
// drain: from the next cycle the head cell presents results in ascending
// signed order, one per cycle while the output is ready, shifting the chain
// toward the head. Input is held off during the drain.
// ---------------------------------------------------------------------------
module signed_int64_set_sorter_core #(
    parameter int MAX_ELEMENTS = sis_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    sis_in_if.sink    in_ch,
    sis_out_if.source out_ch
);
    import sis_pkg::*;

    logic       drain_reg;
    logic       drain_next;
    logic       overflow_reg;
    logic       overflow_next;

    logic       in_xfer;
    logic       out_xfer;
    logic       full;
    sis_ctrl_t  ctrl;

    logic       take_w  [MAX_ELEMENTS];
    logic       valid_w [MAX_ELEMENTS];
    sis_value_t value_w [MAX_ELEMENTS];

    assign full     = valid_w[MAX_ELEMENTS-1];
    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_ch.valid && out_ch.ready;

    assign ctrl.insert    = in_xfer && !full;
    assign ctrl.shift     = out_xfer;
    assign ctrl.new_value = in_ch.value;

    genvar i;
    generate
        for (i = 0; i < MAX_ELEMENTS; i++)
        begin : g_cell
            logic       prev_take;
            logic       prev_valid;
            sis_value_t prev_value;
            logic       next_valid;
            sis_value_t next_value;

            if (i == 0)
            begin : g_head
                assign prev_take  = 1'b0;
                assign prev_valid = 1'b0;
                assign prev_value = '0;
            end
            else
            begin : g_body
                assign prev_take  = take_w[i-1];
                assign prev_valid = valid_w[i-1];
                assign prev_value = value_w[i-1];
            end

            if (i == MAX_ELEMENTS - 1)
            begin : g_tail
                assign next_valid = 1'b0;
                assign next_value = '0;
            end
            else
            begin : g_inner
                assign next_valid = valid_w[i+1];
                assign next_value = value_w[i+1];
            end

            sis_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_take  (prev_take),
                .prev_valid (prev_valid),
                .prev_value (prev_value),
                .next_valid (next_valid),
                .next_value (next_value),
                .take       (take_w[i]),
                .valid      (valid_w[i]),
                .value      (value_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        drain_next    = drain_reg;
        overflow_next = overflow_reg;
        if (in_xfer)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            if (in_ch.last_in)
            begin
                drain_next = 1'b1;
            end
        end
        // Final result taken: set is done, chain is empty again
        if (out_xfer && !valid_w[1])
        begin
            drain_next    = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            drain_reg    <= drain_next;
            overflow_reg <= overflow_next;
        end
    end

    assign in_ch.ready         = !drain_reg;
    assign out_ch.valid        = drain_reg && valid_w[0];
    assign out_ch.sorted_value = value_w[0];
    assign out_ch.last_out     = !valid_w[1];
    assign out_ch.overflow     = overflow_reg;

    // Results and new elements never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input accepted while results pending");

    // Occupied cells start at the head: cell 1 never holds an entry while the head cell is empty
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[1] |-> valid_w[0])
        else $error("hole in the cell chain");

    // Closing transfer always yields a result in the next cycle
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_ch.last_in) |=> out_ch.valid)
        else $error("set end without results");

    // Overflow flag holds for the whole drain
    a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_reg && $past(drain_reg)) |-> $stable(overflow_reg))
        else $error("overflow flag changed during drain");

endmodule

// File: test/signed_int64_set_sorter_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int64_set_sorter_core_tb
// Self-checking bench for the signed 64-bit set sorter.
// ---------------------------------------------------------------------------
// Sets of signed values stream in over the input channel. A scoreboard keeps
// each open set in sorted order and queues the ascending results, with the
// last and overflow flags, once the closing element transfers. Every output
// transfer is compared field by field against the oldest queued result.
// Covers extreme and duplicate values, single-element and full sets, sets
// past capacity, random sets, random idling on both sides and a long output
// hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------
module signed_int64_set_sorter_core_tb;
    import sis_pkg::*;

    localparam int         CAPACITY        = MAX_ELEMENTS_DEFAULT;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam sis_value_t VALUE_MIN       = 64'sh8000_0000_0000_0000;
    localparam sis_value_t VALUE_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        sis_value_t value;
        bit         last;
        bit         overflow;
    } sorted_result_t;

    logic clk;
    logic rst_n;

    sis_in_if  in_ch ();
    sis_out_if out_ch ();

    signed_int64_set_sorter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Scoreboard state: the open set, kept sorted as it fills
    sis_value_t     open_set [CAPACITY];
    int             open_count;
    bit             open_overflow;
    sorted_result_t sorted_expect [$];

    int mismatch_count;
    bit source_idle_on;
    bit sink_idle_on;
    int hold_off_requests;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic sis_value_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return {$urandom(), $urandom()};
        else if (r < 8)
            return sis_value_t'($urandom_range(0, 8)) - 64'sd4;
        else if (r == 8)
            return ($urandom_range(0, 1) != 0) ? VALUE_MAX : VALUE_MIN;
        else
            return ($urandom_range(0, 1) != 0) ? VALUE_MAX - sis_value_t'($urandom_range(0, 3))
                                               : VALUE_MIN + sis_value_t'($urandom_range(0, 3));
    endfunction

    // Place an accepted element into the open set; close the set on last
    function automatic void take_element(input sis_value_t v, input bit last);
        int             i;
        sorted_result_t res;
        if (open_count < CAPACITY)
        begin
            i = open_count;
            while (i > 0 && v < open_set[i-1])
            begin
                open_set[i] = open_set[i-1];
                i--;
            end
            open_set[i] = v;
            open_count++;
        end
        else
            open_overflow = 1'b1;
        if (last)
        begin
            for (i = 0; i < open_count; i++)
            begin
                res.value    = open_set[i];
                res.last     = (i == open_count - 1);
                res.overflow = open_overflow;
                sorted_expect.push_back(res);
            end
            open_count    = 0;
            open_overflow = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
        mismatch_count++;
    endtask

    // Called right after a rising edge; returns right after the transfer edge
    task automatic send_element(input sis_value_t v, input bit last);
        int gap;
        gap = source_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.last_in <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        take_element(v, last);
    endtask

    task automatic send_random_set(input int n);
        for (int k = 0; k < n; k++)
            send_element(pick_value(), k == n - 1);
    endtask

    task automatic wait_drained();
        while (sorted_expect.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        int served;
        stall_left = 0;
        served     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (served != hold_off_requests)
            begin
                served      = hold_off_requests;
                stall_left  = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idle_on && $urandom_range(0, 99) < 25)
            begin
                out_ch.ready <= 1'b0;
                stall_left = pick_gap();
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sorted_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (sorted_expect.size() == 0)
                report_mismatch("unexpected result", out_ch.sorted_value, '0);
            else
            begin
                want = sorted_expect.pop_front();
                if (out_ch.sorted_value !== want.value)
                    report_mismatch("sorted_value", out_ch.sorted_value, want.value);
                if (out_ch.last_out !== want.last)
                    report_mismatch("last_out", 64'(out_ch.last_out), 64'(want.last));
                if (out_ch.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(out_ch.overflow), 64'(want.overflow));
            end
        end
    end

    // Extremes, duplicates, single element and reversed sets
    task automatic test_directed();
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        send_element(64'sd0, 1'b1);
        send_element(VALUE_MAX, 1'b0);
        send_element(VALUE_MIN, 1'b0);
        send_element(-64'sd1, 1'b0);
        send_element(64'sd0, 1'b0);
        send_element(64'sd1, 1'b0);
        send_element(VALUE_MAX, 1'b0);
        send_element(VALUE_MIN, 1'b0);
        send_element(-64'sd1, 1'b1);
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        send_element(64'sh5555_5555_5555_5555, 1'b0);
        send_element(64'shAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_element(VALUE_MAX - 64'sd1, 1'b0);
        send_element(VALUE_MIN + 64'sd1, 1'b0);
        send_element(64'sd2, 1'b1);
        send_element(64'sd100, 1'b0);
        send_element(64'sd50, 1'b0);
        send_element(64'sd0, 1'b0);
        send_element(-64'sd50, 1'b0);
        send_element(-64'sd100, 1'b1);
    endtask

    // Exactly full set, then a set past capacity whose closing element is dropped
    task automatic test_capacity();
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b1;
        send_random_set(CAPACITY);
        source_idle_on = 1'b1;
        send_random_set(CAPACITY + 2);
        send_element(64'sd7, 1'b1);
    endtask

    // Hold the output off while two sets are offered back to back
    task automatic test_backpressure();
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        hold_off_requests <= hold_off_requests + 1;
        send_random_set(20);
        send_random_set(10);
        sink_idle_on = 1'b1;
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        int r;
        sent = 0;
        while (sent < 40)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                n = $urandom_range(1, 10);
            else if (r < 96)
                n = $urandom_range(11, 40);
            else
                n = $urandom_range(CAPACITY - 2, CAPACITY + 4);
            source_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on   = ($urandom_range(0, 3) != 0);
            send_random_set(n);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.value       = '0;
        in_ch.last_in     = 1'b0;
        out_ch.ready      = 1'b0;
        open_count        = 0;
        open_overflow     = 1'b0;
        mismatch_count    = 0;
        hold_off_requests = 0;
        source_idle_on    = 1'b0;
        sink_idle_on      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity();
        test_backpressure();
        test_random_sets();

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (2 * CAPACITY + 20) @(posedge clk);
        if (mismatch_count == 0 && sorted_expect.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
src/sis_pkg.sv
src/sis_if.sv
src/sis_cell.sv
src/signed_int64_set_sorter_core.sv
test/signed_int64_set_sorter_core_tb.sv
